// ===== sv/bkvs_pkg.sv =====
// Shared types and field widths of the best-k vector store.
package bkvs_pkg;

	localparam int KIND_W  = 2;
	localparam int PROJ_W  = 10;
	localparam int NORM_W  = 32;
	localparam int CO_W    = 16;
	localparam int SLOT_W  = 8;
	localparam int IDX_W   = 7;
	localparam int COUNT_W = 9;
	localparam int LEN_W   = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_READ   = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_COPY,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                     accepted;
		logic [SLOT_W-1:0]        target_slot;
		logic                     truncated;
		logic [COUNT_W-1:0]       occupied_count;
		logic                     entry_valid;
		logic [PROJ_W-1:0]        entry_projection;
		logic [NORM_W-1:0]        entry_norm;
		logic [LEN_W-1:0]         entry_length;
		logic signed [CO_W-1:0]   entry_coeff;
	} result_t;

endpackage

// ===== sv/bkvs_if.sv =====
// Valid/ready channel interfaces for input and result words.
interface bkvs_in_if import bkvs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [KIND_W-1:0]      kind;
	logic [PROJ_W-1:0]      projection;
	logic [NORM_W-1:0]      norm;
	logic signed [CO_W-1:0] coeff;
	logic                   last;
	logic [SLOT_W-1:0]      read_slot;
	logic [IDX_W-1:0]       read_index;

	modport source (output valid, kind, projection, norm, coeff, last, read_slot, read_index,
		input ready);
	modport sink (input valid, kind, projection, norm, coeff, last, read_slot, read_index,
		output ready);
endinterface

interface bkvs_out_if import bkvs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   accepted;
	logic [SLOT_W-1:0]      target_slot;
	logic                   truncated;
	logic [COUNT_W-1:0]     occupied_count;
	logic                   entry_valid;
	logic [PROJ_W-1:0]      entry_projection;
	logic [NORM_W-1:0]      entry_norm;
	logic [LEN_W-1:0]       entry_length;
	logic signed [CO_W-1:0] entry_coeff;

	modport source (output valid, accepted, target_slot, truncated, occupied_count, entry_valid,
		entry_projection, entry_norm, entry_length, entry_coeff, input ready);
	modport sink (input valid, accepted, target_slot, truncated, occupied_count, entry_valid,
		entry_projection, entry_norm, entry_length, entry_coeff, output ready);
endinterface

// ===== sv/bkvs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bkvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/best_k_vector_store.sv =====
// Top level of the best-k vector store.
// Keeps up to SLOTS vectors; each slot has a header (projection, Q16.16 norm, length) in one
// RAM and MAX_COEFFS coefficients in a second RAM, with valid bits in flops. A final insert
// word scans the headers of slots 0..n-1 (n = slots_cfg_q clamped to 1..SLOTS)
// one slot per cycle through the header RAM read port, then copies the vector out of the
// staging RAM when it is taken, then hands the result to the output. One word is worked
// on at a time; the result register lets a new word enter while the previous result waits.
module best_k_vector_store import bkvs_pkg::*; #(
	parameter int SLOTS       = 256,
	parameter int MAX_COEFFS  = 128,
	parameter int COEFF_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_data,
	bkvs_in_if.sink            in_ch,
	bkvs_out_if.source         out_ch
);

	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NW  = $clog2(SLOTS + 1);
	localparam int XW  = $clog2(MAX_COEFFS);
	localparam int LW  = $clog2(MAX_COEFFS + 1);
	localparam int CAW = (SLOTS * MAX_COEFFS > 1) ? $clog2(SLOTS * MAX_COEFFS) : 1;
	localparam int HW  = PROJ_W + NORM_W + LW;

	state_t state_q, state_d;

	logic [COUNT_W-1:0] slots_cfg_q;
	logic [NW-1:0]      n_act;
	logic [SW-1:0]      last_idx;

	logic [SLOTS-1:0]   valid_q;
	logic [NW-1:0]      count_q, count_next;
	logic [LW-1:0]      stg_len_q, stg_len_new;
	logic               stg_ovf_q, stg_ovf_new;

	logic [LW-1:0]      ins_len_q;
	logic               ins_ovf_q;
	logic [PROJ_W-1:0]  ins_proj_q;
	logic [NORM_W-1:0]  ins_norm_q;

	logic [SW-1:0]      scan_q, idx_s1, empty_q, worst_q, target;
	logic               scan_done_q, vld_s1, sv_s1, found_q, take;
	logic [PROJ_W-1:0]  best_proj_q;
	logic [NORM_W-1:0]  best_norm_q;
	logic [CAW-1:0]     base_q;
	logic [LW-1:0]      copy_q;

	logic               rd_ok_s1;
	logic [IDX_W-1:0]   rd_idx_s1;

	result_t            pend_q, res_q;
	result_t            dec_res, rd_res;
	logic               out_valid_q;

	logic               in_fire, emit_go;
	kind_t              kind;

	// header RAM
	logic               hdr_we;
	logic [SW-1:0]      hdr_waddr, hdr_raddr;
	logic [HW-1:0]      hdr_wdata, hdr_rdata;
	logic [PROJ_W-1:0]  h_proj;
	logic [NORM_W-1:0]  h_norm;
	logic [LW-1:0]      h_len;

	// coefficient and staging RAMs
	logic               coef_we, stg_we;
	logic [CAW-1:0]     coef_waddr, coef_raddr;
	logic [COEFF_WIDTH-1:0] coef_rdata, stg_wdata, stg_rdata;
	logic [XW-1:0]      stg_waddr, stg_raddr;

	logic signed [31:0] cin_ext, cout_ext;
	logic signed [COEFF_WIDTH-1:0] cout_s;
	logic [SW-1:0]      rd_slot;
	logic               rd_in_range;

	assign kind    = kind_t'(in_ch.kind);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ch.ready);

	always_comb begin
		if (slots_cfg_q == '0)
			n_act = NW'(1);
		else if (32'(slots_cfg_q) > SLOTS)
			n_act = NW'(SLOTS);
		else
			n_act = NW'(slots_cfg_q);
	end
	assign last_idx = SW'(n_act - NW'(1));

	assign stg_len_new = (32'(stg_len_q) < MAX_COEFFS) ? stg_len_q + LW'(1) : stg_len_q;
	assign stg_ovf_new = stg_ovf_q || (32'(stg_len_q) >= MAX_COEFFS);

	assign {h_proj, h_norm, h_len} = hdr_rdata;
	assign target = found_q ? empty_q : worst_q;
	assign take   = found_q || (ins_proj_q < best_proj_q) ||
		((ins_proj_q == best_proj_q) && (ins_norm_q < best_norm_q));
	assign count_next = count_q + NW'(take && found_q);

	assign cin_ext  = 32'(in_ch.coeff);
	assign cout_s   = coef_rdata;
	assign cout_ext = 32'(cout_s);
	assign rd_slot  = SW'(in_ch.read_slot);
	assign rd_in_range = 32'(in_ch.read_slot) < SLOTS;

	// result words for the insert decision and for a read
	always_comb begin
		dec_res                = '0;
		dec_res.accepted       = take;
		dec_res.target_slot    = SLOT_W'(target);
		dec_res.truncated      = ins_ovf_q;
		dec_res.occupied_count = COUNT_W'(count_next);

		rd_res                = '0;
		rd_res.occupied_count = COUNT_W'(count_q);
		if (rd_ok_s1) begin
			rd_res.entry_valid      = 1'b1;
			rd_res.entry_projection = h_proj;
			rd_res.entry_norm       = h_norm;
			rd_res.entry_length     = LEN_W'(h_len);
			if (32'(rd_idx_s1) < 32'(h_len) && 32'(rd_idx_s1) < MAX_COEFFS)
				rd_res.entry_coeff = cout_ext[CO_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (kind)
						KIND_INSERT: if (in_ch.last) state_d = ST_SCAN;
						KIND_READ:   state_d = ST_READ;
						KIND_CLEAR:  state_d = ST_EMIT;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN:   if (vld_s1 && idx_s1 == last_idx) state_d = ST_DECIDE;
			ST_DECIDE: state_d = take ? ST_COPY : ST_EMIT;
			ST_COPY:   if (copy_q == ins_len_q) state_d = ST_EMIT;
			ST_READ:   state_d = ST_EMIT;
			ST_EMIT:   if (emit_go) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		hdr_we      = (state_q == ST_DECIDE) && take;
		hdr_waddr   = target;
		hdr_wdata   = {ins_proj_q, ins_norm_q, ins_len_q};
		hdr_raddr   = (state_q == ST_IDLE) ? rd_slot : scan_q;
		stg_we      = in_fire && (kind == KIND_INSERT) && (32'(stg_len_q) < MAX_COEFFS);
		stg_waddr   = XW'(stg_len_q);
		stg_wdata   = cin_ext[COEFF_WIDTH-1:0];
		stg_raddr   = XW'(copy_q);
		coef_we     = (state_q == ST_COPY) && (copy_q != '0);
		coef_waddr  = base_q + CAW'(copy_q - LW'(1));
		coef_raddr  = CAW'(rd_slot) * CAW'(MAX_COEFFS) + CAW'(in_ch.read_index);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slots_cfg_q <= COUNT_W'(256);
			valid_q     <= '0;
			count_q     <= '0;
			stg_len_q   <= '0;
			stg_ovf_q   <= 1'b0;
			ins_len_q   <= '0;
			ins_ovf_q   <= 1'b0;
			ins_proj_q  <= '0;
			ins_norm_q  <= '0;
			scan_q      <= '0;
			scan_done_q <= 1'b0;
			vld_s1      <= 1'b0;
			sv_s1       <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			empty_q     <= '0;
			worst_q     <= '0;
			best_proj_q <= '0;
			best_norm_q <= '0;
			base_q      <= '0;
			copy_q      <= '0;
			rd_ok_s1    <= 1'b0;
			rd_idx_s1   <= '0;
			pend_q      <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				slots_cfg_q <= cfg_data;

			if (emit_go) begin
				out_valid_q <= 1'b1;
				res_q       <= pend_q;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (kind)
							KIND_INSERT: begin
								if (in_ch.last) begin
									ins_len_q   <= stg_len_new;
									ins_ovf_q   <= stg_ovf_new;
									ins_proj_q  <= in_ch.projection;
									ins_norm_q  <= in_ch.norm;
									stg_len_q   <= '0;
									stg_ovf_q   <= 1'b0;
									scan_q      <= '0;
									scan_done_q <= 1'b0;
									vld_s1      <= 1'b0;
									found_q     <= 1'b0;
								end else begin
									stg_len_q <= stg_len_new;
									stg_ovf_q <= stg_ovf_new;
								end
							end
							KIND_READ: begin
								rd_ok_s1  <= rd_in_range && valid_q[rd_slot];
								rd_idx_s1 <= in_ch.read_index;
							end
							KIND_CLEAR: begin
								valid_q   <= '0;
								count_q   <= '0;
								stg_len_q <= '0;
								stg_ovf_q <= 1'b0;
								pend_q    <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					// header of idx_s1 arrives in the cycle after its address
					if (!scan_done_q) begin
						if (scan_q != last_idx)
							scan_q <= scan_q + SW'(1);
						scan_done_q <= (scan_q == last_idx);
					end
					vld_s1 <= !scan_done_q;
					idx_s1 <= scan_q;
					sv_s1  <= valid_q[scan_q];
					if (vld_s1) begin
						if (!sv_s1) begin
							if (!found_q) begin
								found_q <= 1'b1;
								empty_q <= idx_s1;
							end
						end else if (idx_s1 == '0 || h_proj > best_proj_q ||
							(h_proj == best_proj_q && h_norm > best_norm_q)) begin
							worst_q     <= idx_s1;
							best_proj_q <= h_proj;
							best_norm_q <= h_norm;
						end
					end
				end
				ST_DECIDE: begin
					if (take)
						valid_q[target] <= 1'b1;
					count_q <= count_next;
					base_q  <= CAW'(target) * CAW'(MAX_COEFFS);
					copy_q  <= '0;
					pend_q  <= dec_res;
				end
				ST_COPY: begin
					if (copy_q != ins_len_q)
						copy_q <= copy_q + LW'(1);
				end
				ST_READ: begin
					pend_q <= rd_res;
				end
				default: ;
			endcase
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.accepted         = res_q.accepted;
	assign out_ch.target_slot      = res_q.target_slot;
	assign out_ch.truncated        = res_q.truncated;
	assign out_ch.occupied_count   = res_q.occupied_count;
	assign out_ch.entry_valid      = res_q.entry_valid;
	assign out_ch.entry_projection = res_q.entry_projection;
	assign out_ch.entry_norm       = res_q.entry_norm;
	assign out_ch.entry_length     = res_q.entry_length;
	assign out_ch.entry_coeff      = res_q.entry_coeff;

	bkvs_ram #(.WIDTH(HW), .DEPTH(SLOTS), .AW(SW)) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (hdr_waddr),
		.wdata (hdr_wdata),
		.raddr (hdr_raddr),
		.rdata (hdr_rdata)
	);

	bkvs_ram #(.WIDTH(COEFF_WIDTH), .DEPTH(SLOTS * MAX_COEFFS), .AW(CAW)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (stg_rdata),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	bkvs_ram #(.WIDTH(COEFF_WIDTH), .DEPTH(MAX_COEFFS), .AW(XW)) u_stg_ram (
		.clk   (clk),
		.we    (stg_we),
		.waddr (stg_waddr),
		.wdata (stg_wdata),
		.raddr (stg_raddr),
		.rdata (stg_rdata)
	);

endmodule
